@@ rtl/hd84_pkg.sv @@
// shared widths, types and constants for the soft [8,4] block decoder
// no dependencies; used by hd84_square, hd84_pair, hd84_coset, the top level and the testbench
`default_nettype none

package hd84_pkg;

  localparam int unsigned NUM_COEF = 8;
  localparam int unsigned NUM_PAIR = NUM_COEF / 2;
  localparam int unsigned COEF_W   = 12;
  // distance to 0 or to the midpoint never exceeds 2048
  localparam int unsigned DIST_W   = 12;
  localparam int unsigned SQ_W     = 23;
  localparam int unsigned COST_W   = SQ_W + 1;
  // four chosen costs plus one fix-up difference
  localparam int unsigned TOT_W    = COST_W + 3;
  localparam int unsigned NIB_W    = 4;

  localparam logic [COEF_W-1:0] HALF = 12'h800;

  typedef logic [COEF_W-1:0] coef_t;
  typedef logic [SQ_W-1:0]   sq_t;
  typedef logic [COST_W-1:0] cost_t;
  typedef logic [TOT_W-1:0]  total_t;

  // squared distances of one coefficient: to 0 on the circle and to the midpoint
  typedef struct packed {
    sq_t c0;
    sq_t c1;
  } sq_pair_t;

  // one pair decision inside one coset
  typedef struct packed {
    logic  one;
    cost_t chosen;
    cost_t diff;
  } pair_dec_t;

  // result of one coset after the parity fix
  typedef struct packed {
    total_t     total;
    logic [2:0] bits;
  } coset_res_t;

endpackage

`default_nettype wire

@@ rtl/hd84_square.sv @@
// per-coefficient squared distances to 0 (circular) and to the midpoint
// uses hd84_pkg
`default_nettype none

module hd84_square (
  input  wire hd84_pkg::coef_t    coef [hd84_pkg::NUM_COEF],
  output hd84_pkg::sq_pair_t sq   [hd84_pkg::NUM_COEF]
);

  always_comb begin
    logic [hd84_pkg::DIST_W-1:0]   d0;
    logic [hd84_pkg::DIST_W-1:0]   d1;
    logic [2*hd84_pkg::DIST_W-1:0] p0;
    logic [2*hd84_pkg::DIST_W-1:0] p1;
    for (int i = 0; i < hd84_pkg::NUM_COEF; i++) begin
      // upper half wraps: distance is 4096 - x, which is the 12-bit negation
      d0 = coef[i][hd84_pkg::COEF_W-1] ? (hd84_pkg::DIST_W'(0) - coef[i]) : coef[i];
      d1 = coef[i][hd84_pkg::COEF_W-1] ? (coef[i] - hd84_pkg::HALF)
                                        : (hd84_pkg::HALF - coef[i]);
      p0 = d0 * d0;
      p1 = d1 * d1;
      sq[i].c0 = p0[hd84_pkg::SQ_W-1:0];
      sq[i].c1 = p1[hd84_pkg::SQ_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/hd84_pair.sv @@
// pair label decisions for both cosets: cheaper label, its cost and the margin
// uses hd84_pkg
`default_nettype none

module hd84_pair (
  input  wire hd84_pkg::sq_pair_t  sq  [hd84_pkg::NUM_COEF],
  output hd84_pkg::pair_dec_t dec [2][hd84_pkg::NUM_PAIR]
);

  function automatic hd84_pkg::pair_dec_t decide(hd84_pkg::cost_t cost0,
                                                 hd84_pkg::cost_t cost1);
    hd84_pkg::pair_dec_t r;
    r.one    = cost1 < cost0;
    r.chosen = r.one ? cost1 : cost0;
    r.diff   = r.one ? (cost0 - cost1) : (cost1 - cost0);
    return r;
  endfunction

  always_comb begin
    hd84_pkg::sq_pair_t e;
    hd84_pkg::sq_pair_t o;
    for (int k = 0; k < hd84_pkg::NUM_PAIR; k++) begin
      e = sq[2*k];
      o = sq[2*k+1];
      dec[0][k] = decide(hd84_pkg::COST_W'(e.c0) + hd84_pkg::COST_W'(o.c0),
                         hd84_pkg::COST_W'(e.c1) + hd84_pkg::COST_W'(o.c1));
      dec[1][k] = decide(hd84_pkg::COST_W'(e.c1) + hd84_pkg::COST_W'(o.c0),
                         hd84_pkg::COST_W'(e.c0) + hd84_pkg::COST_W'(o.c1));
    end
  end

endmodule

`default_nettype wire

@@ rtl/hd84_coset.sv @@
// one coset: total cost, smallest-margin pair, parity fix, nibble bits 3..1
// uses hd84_pkg
`default_nettype none

module hd84_coset (
  input  wire hd84_pkg::pair_dec_t  dec [hd84_pkg::NUM_PAIR],
  output hd84_pkg::coset_res_t res
);

  always_comb begin
    hd84_pkg::total_t sum;
    hd84_pkg::cost_t  best_diff;
    logic [1:0]       best_pair;
    logic [3:0]       labels;
    logic             parity;
    sum       = '0;
    labels    = '0;
    parity    = 1'b0;
    best_diff = dec[0].diff;
    best_pair = 2'd0;
    for (int k = 0; k < hd84_pkg::NUM_PAIR; k++) begin
      sum       = sum + hd84_pkg::TOT_W'(dec[k].chosen);
      labels[k] = dec[k].one;
      parity    = parity ^ dec[k].one;
    end
    // strict less-than keeps the lowest pair on equal margins
    for (int k = 1; k < hd84_pkg::NUM_PAIR; k++) begin
      if (dec[k].diff < best_diff) begin
        best_diff = dec[k].diff;
        best_pair = 2'(k);
      end
    end
    if (parity) begin
      sum               = sum + hd84_pkg::TOT_W'(best_diff);
      labels[best_pair] = ~labels[best_pair];
    end
    res.total = sum;
    res.bits  = {labels[3], labels[0] ^ labels[1], labels[0]};
  end

endmodule

`default_nettype wire

@@ rtl/soft_hamming84_block_decoder.sv @@
// top level of the soft [8,4] block decoder: five register stages
// uses hd84_pkg, hd84_square, hd84_pair, hd84_coset
//
// channel | direction | handshake            | payload
// input   | in        | in_valid / in_ready  | coef_0 .. coef_7, 12 bits each
// output  | out       | out_valid / out_ready| nibble, 4 bits
//
// one block per cycle sustained while out_ready stays high; a request taken at the input
// passes through the input reg, squares, pair decisions, coset sums and final select
// registers before its result shows valid
// each stage holds while the stage after it is full and stalled, so bubbles
// are squeezed out and in_ready stays high while any stage is empty
// synchronous reset clears the stage valid bits only
`default_nettype none

module soft_hamming84_block_decoder (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire hd84_pkg::coef_t       coef_0,
  input  wire hd84_pkg::coef_t       coef_1,
  input  wire hd84_pkg::coef_t       coef_2,
  input  wire hd84_pkg::coef_t       coef_3,
  input  wire hd84_pkg::coef_t       coef_4,
  input  wire hd84_pkg::coef_t       coef_5,
  input  wire hd84_pkg::coef_t       coef_6,
  input  wire hd84_pkg::coef_t       coef_7,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic [hd84_pkg::NIB_W-1:0] nibble
);

  logic v1, v2, v3, v4, v5;
  logic r1, r2, r3, r4, r5;

  hd84_pkg::coef_t      coef_r  [hd84_pkg::NUM_COEF];
  hd84_pkg::sq_pair_t   sq      [hd84_pkg::NUM_COEF];
  hd84_pkg::sq_pair_t   sq_r    [hd84_pkg::NUM_COEF];
  hd84_pkg::pair_dec_t  dec     [2][hd84_pkg::NUM_PAIR];
  hd84_pkg::pair_dec_t  dec_r   [2][hd84_pkg::NUM_PAIR];
  hd84_pkg::coset_res_t cres    [2];
  hd84_pkg::coset_res_t cres_r  [2];
  logic [hd84_pkg::NIB_W-1:0] nibble_next;

  // a stage can load when it is empty or its content moves on
  assign r5       = !v5 || out_ready;
  assign r4       = !v4 || r5;
  assign r3       = !v3 || r4;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;
  assign out_valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      coef_r[0] <= coef_0;
      coef_r[1] <= coef_1;
      coef_r[2] <= coef_2;
      coef_r[3] <= coef_3;
      coef_r[4] <= coef_4;
      coef_r[5] <= coef_5;
      coef_r[6] <= coef_6;
      coef_r[7] <= coef_7;
    end
    if (r2 && v1) sq_r   <= sq;
    if (r3 && v2) dec_r  <= dec;
    if (r4 && v3) cres_r <= cres;
    if (r5 && v4) nibble <= nibble_next;
  end

  hd84_square u_square (
    .coef (coef_r),
    .sq   (sq)
  );

  hd84_pair u_pair (
    .sq  (sq_r),
    .dec (dec)
  );

  hd84_coset u_coset0 (
    .dec (dec_r[0]),
    .res (cres[0])
  );

  hd84_coset u_coset1 (
    .dec (dec_r[1]),
    .res (cres[1])
  );

  // coset 0 wins a tie
  always_comb begin
    if (cres_r[1].total < cres_r[0].total) begin
      nibble_next = {cres_r[1].bits, 1'b1};
    end else begin
      nibble_next = {cres_r[0].bits, 1'b0};
    end
  end

endmodule

`default_nettype wire

@@ rtl/hd84_checker.sv @@
// port-level checks for the soft [8,4] block decoder, bound to the top level
// depends on soft_hamming84_block_decoder port names
`default_nettype none

module hd84_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [3:0] nibble
);

  // a stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(nibble))
    else $error("stalled result changed");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // with the last stage empty no stage can block a new request
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output stage");

  // a result cannot appear without a request ahead of it
  a_cause: assert property (@(posedge clk) disable iff (rst)
    !in_valid ##1 !in_valid ##1 !in_valid ##1 !in_valid ##1 !in_valid ##1 out_ready
    |-> !out_valid || $past(out_valid))
    else $error("result with no pending request");

endmodule

bind soft_hamming84_block_decoder hd84_checker u_hd84_checker (.*);

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// testbench for soft_hamming84_block_decoder: drives coefficient blocks, predicts each
// decoded nibble with its own maximum-likelihood decoder and checks results in order
// depends on rtl/hd84_pkg.sv and the decoder rtl

typedef hd84_pkg::coef_t [hd84_pkg::NUM_COEF-1:0] coef_blk_t;

class nibble_scoreboard;
  logic [hd84_pkg::NIB_W-1:0] expected_q[$];
  int unsigned checked = 0;
  int unsigned errors = 0;

  // soft decode over both cosets with a parity fix per coset, first minimum wins on ties
  function logic [hd84_pkg::NIB_W-1:0] ml_nibble(coef_blk_t b);
    logic [31:0] to_zero[8];
    logic [31:0] to_mid[8];
    logic [31:0] total[2];
    logic [31:0] best_diff[2];
    logic [1:0]  best_pair[2];
    logic [3:0]  lab[2];
    logic [3:0]  nib[2];
    logic [31:0] x, d, cost0, cost1, lo, hi;
    logic        one;
    for (int i = 0; i < 8; i++) begin
      x = 32'(b[i]);
      d = (x < 32'd4096 - x) ? x : 32'd4096 - x;
      to_zero[i] = d * d;
      d = (x >= 32'd2048) ? x - 32'd2048 : 32'd2048 - x;
      to_mid[i] = d * d;
    end
    for (int s = 0; s < 2; s++) begin
      total[s]     = '0;
      best_diff[s] = '1;
      best_pair[s] = '0;
      lab[s]       = '0;
      for (int k = 0; k < 4; k++) begin
        if (s == 0) begin
          cost0 = to_zero[2*k] + to_zero[2*k+1];
          cost1 = to_mid[2*k] + to_mid[2*k+1];
        end else begin
          cost0 = to_mid[2*k] + to_zero[2*k+1];
          cost1 = to_zero[2*k] + to_mid[2*k+1];
        end
        one = cost1 < cost0;
        lo  = one ? cost1 : cost0;
        hi  = one ? cost0 : cost1;
        lab[s][k] = one;
        total[s] += lo;
        if (hi - lo < best_diff[s]) begin
          best_diff[s] = hi - lo;
          best_pair[s] = 2'(k);
        end
      end
      // odd label parity: flip the cheapest pair
      if (^lab[s]) begin
        total[s] += best_diff[s];
        lab[s][best_pair[s]] = ~lab[s][best_pair[s]];
      end
      nib[s] = {lab[s][3], lab[s][0] ^ lab[s][1], lab[s][0], 1'(s)};
    end
    return (total[1] < total[0]) ? nib[1] : nib[0];
  endfunction

  function void note_request(coef_blk_t b);
    expected_q.push_back(ml_nibble(b));
  endfunction

  function void check_result(logic [hd84_pkg::NIB_W-1:0] got);
    logic [hd84_pkg::NIB_W-1:0] exp_nib;
    checked++;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: nibble %h arrived with no request outstanding", $time, got);
    end else begin
      exp_nib = expected_q.pop_front();
      if (got !== exp_nib) begin
        errors++;
        $display("%0t: nibble mismatch, expected %h, actual %h", $time, exp_nib, got);
      end
    end
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction
endclass

module tb_top;
  localparam int unsigned RANDOM_BLOCKS = 2000;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  coef_blk_t                  drv_blk;
  logic                       out_valid;
  logic                       out_ready;
  logic [hd84_pkg::NIB_W-1:0] nibble;

  nibble_scoreboard sb = new();

  int unsigned n_sent = 0;
  int unsigned n_directed = 0;
  int unsigned n_codeword = 0;

  rx_mode_t    rx_mode = RX_FREE;
  int unsigned rx_left = 0;
  logic [3:0]  rx_cnt = '0;

  hd84_pkg::coef_t corner_vals[12] = '{12'd0, 12'd1, 12'd1023, 12'd1024, 12'd1025, 12'd2047,
                                       12'd2048, 12'd2049, 12'd3071, 12'd3072, 12'd3073,
                                       12'd4095};

  soft_hamming84_block_decoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .coef_0    (drv_blk[0]),
    .coef_1    (drv_blk[1]),
    .coef_2    (drv_blk[2]),
    .coef_3    (drv_blk[3]),
    .coef_4    (drv_blk[4]),
    .coef_5    (drv_blk[5]),
    .coef_6    (drv_blk[6]),
    .coef_7    (drv_blk[7]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .nibble    (nibble)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ideal codeword for nibble n, each coefficient moved by up to +/- noise
  function automatic coef_blk_t codeword(logic [3:0] n, int unsigned noise);
    coef_blk_t  b;
    logic [3:0] lab;
    logic       s;
    s      = n[0];
    lab[0] = n[1];
    lab[1] = n[2] ^ n[1];
    lab[3] = n[3];
    lab[2] = lab[0] ^ lab[1] ^ lab[3];
    for (int k = 0; k < 4; k++) begin
      b[2*k]   = {s ^ lab[k], 11'd0};
      b[2*k+1] = {lab[k], 11'd0};
    end
    for (int i = 0; i < 8; i++)
      b[i] = b[i] + 12'($urandom_range(0, 2 * noise)) - 12'(noise);
    return b;
  endfunction

  function automatic coef_blk_t random_block();
    coef_blk_t   b;
    int unsigned noise_lvl[4] = '{0, 96, 600, 1023};
    case ($urandom_range(0, 7))
      0, 1, 2, 3: begin
        n_codeword++;
        b = codeword(4'($urandom), noise_lvl[$urandom_range(0, 3)]);
      end
      4, 5: begin
        for (int i = 0; i < 8; i++) b[i] = 12'($urandom);
      end
      6: begin
        for (int i = 0; i < 8; i++) b[i] = corner_vals[$urandom_range(0, 11)];
      end
      default: begin
        // codeword with one coefficient wiped out
        n_codeword++;
        b = codeword(4'($urandom), 64);
        b[$urandom_range(0, 7)] = 12'($urandom);
      end
    endcase
    return b;
  endfunction

  // holds the request until the decoder takes it
  task automatic send_block(coef_blk_t b);
    in_valid <= 1'b1;
    drv_blk  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // output side stalls in its own modes, each lasting a random stretch
  always @(posedge clk) begin
    rx_cnt <= rx_cnt + 4'd1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_FREE:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom);
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= (rx_cnt < 4'd2);
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(nibble);
      if (in_valid && in_ready) sb.note_request(drv_blk);
    end
  end

  initial begin
    coef_blk_t   b;
    int unsigned burst, gap;
    bit          mid_drain;
    mid_drain = 1'b0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    drv_blk   <= '0;
    out_ready <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, equal-cost points, half-scale patterns, every clean codeword
    send_block({8{12'd0}});
    send_block({8{12'd4095}});
    send_block({8{12'd2048}});
    send_block({8{12'd1024}});
    send_block({8{12'd3072}});
    send_block({8{12'd2049}});
    b = '0;
    for (int i = 1; i < 8; i += 2) b[i] = 12'd2048;
    send_block(b);
    send_block(~b & {8{12'h800}});
    b    = '0;
    b[0] = 12'd2048;
    send_block(b);
    for (int n = 0; n < 16; n++) send_block(codeword(4'(n), 0));
    n_directed = n_sent;
    wait_drained();

    while (n_sent < n_directed + RANDOM_BLOCKS) begin
      burst = $urandom_range(1, 40);
      repeat (burst) send_block(random_block());
      if (!mid_drain && n_sent > n_directed + RANDOM_BLOCKS / 2) begin
        mid_drain = 1'b1;
        wait_drained();
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("sent %0d blocks (%0d directed, %0d codeword based), checked %0d nibbles",
             n_sent, n_directed, n_codeword, sb.checked);
    $display("%0d mismatches, %0d requests outstanding", sb.errors, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[soft_hamming84_block_decoder] OK");
    end else begin
      $display("[soft_hamming84_block_decoder] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d requests outstanding", sb.pending());
    $display("[soft_hamming84_block_decoder] ERROR");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/hd84_pkg.sv
rtl/hd84_square.sv
rtl/hd84_pair.sv
rtl/hd84_coset.sv
rtl/soft_hamming84_block_decoder.sv
rtl/hd84_checker.sv
test/tb_top.sv
